>>> rtl/core/dla_pkg.sv
`default_nettype none

package dla_pkg;

  // Default geometry: coordinate bits and fraction bits of the minor accumulator
  localparam int COORD_BITS_DEF = 12;
  localparam int FRAC_BITS_DEF  = 16;

  // Colour layout: three 8-bit channels, channel 0 in the low byte
  localparam int COLOR_W  = 24;
  localparam int CHAN_W   = 8;
  localparam int NUM_CHAN = 3;

  // Blend weight fraction and rounding term
  localparam int BLEND_W  = 8;
  localparam int BLEND_RND = 128;

  // Configuration register map
  localparam int          APB_ADDR_W     = 3;
  localparam int          APB_DATA_W     = 32;
  localparam logic        REG_LINE_COLOR = 1'b0;
  localparam logic        REG_ANTIALIAS  = 1'b1;
  localparam logic [23:0] LINE_COLOR_RST = 24'h0000ff;

  // Request opcodes
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_START,
    ST_DIV,
    ST_MUL,
    ST_PIX0,
    ST_PIX1
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic ld_line;
    logic kill;
    logic div_start;
    logic slope_wr;
    logic mul_en;
    logic emit0;
    logic emit1;
    logic advance;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic degenerate;
    logic step_ok;
    logic aa_mode;
    logic div_done;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

>>> rtl/core/dla_div.sv
`default_nettype none

module dla_div #(
  parameter int DIVIDEND_W = 28,
  parameter int DIVISOR_W  = 12
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire logic [DIVIDEND_W-1:0] dividend_i,
  input  wire logic [DIVISOR_W-1:0]  divisor_i,
  output logic                       done_o,
  output logic [DIVIDEND_W-1:0]      quotient_o
);

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic [DIVISOR_W-1:0]  rem_q, rem_d;
  logic [DIVIDEND_W-1:0] quo_q, quo_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [DIVISOR_W:0]    trial;
  logic [DIVISOR_W:0]    diff;
  logic                  ge;

  // One restoring step: bring down the next dividend bit and try a subtract
  always_comb begin
    trial = {rem_q, quo_q[DIVIDEND_W-1]};
    diff  = trial - {1'b0, divisor_i};
    ge    = (trial >= {1'b0, divisor_i});
  end

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = dividend_i;
      cnt_d  = CNT_W'(DIVIDEND_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
      quo_d = {quo_q[DIVIDEND_W-2:0], ge};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

>>> rtl/core/dla_datapath.sv
`default_nettype none

module dla_datapath #(
  parameter int COORD_BITS = dla_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = dla_pkg::FRAC_BITS_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire dla_pkg::dp_cmd_t             cmd_i,
  output dla_pkg::dp_status_t               status_o,
  input  wire logic [COORD_BITS-1:0]        x_start_i,
  input  wire logic [COORD_BITS-1:0]        y_start_i,
  input  wire logic [COORD_BITS-1:0]        x_end_i,
  input  wire logic [COORD_BITS-1:0]        y_end_i,
  input  wire logic [dla_pkg::COLOR_W-1:0]  background_color_i,
  input  wire logic [dla_pkg::COLOR_W-1:0]  line_color_i,
  input  wire logic                         antialias_on_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic [COORD_BITS:0]               pixel_x_o,
  output logic [COORD_BITS:0]               pixel_y_o,
  output logic [dla_pkg::COLOR_W-1:0]       pixel_color_o,
  output logic                              last_of_line_o
);

  import dla_pkg::*;

  localparam int CW = COORD_BITS;
  localparam int PW = COORD_BITS + 1;
  localparam int AW = COORD_BITS + FRAC_BITS;
  localparam int QW = FRAC_BITS + 1;
  localparam int SW = FRAC_BITS + 2;
  localparam int MW = 2 * (CHAN_W + 1);

  // Line state
  logic [CW-1:0]        pos_q, limit_q;
  logic [AW-1:0]        acc_q;
  logic signed [SW-1:0] slope_q;
  logic                 y_major_q, active_q, neg_q, mode_q;
  logic [COLOR_W-1:0]   bg_q;
  logic [CW-1:0]        dmaj_q, dmin_q;
  logic signed [MW-1:0] prod_q [NUM_CHAN];

  // Result register
  logic                 out_valid_q, out_valid_d;
  logic [PW-1:0]        px_q, py_q, px_d, py_d;
  logic [COLOR_W-1:0]   color_q, color_d;
  logic                 last_q, last_d;

  // Load set-up: axis choice and endpoint ordering
  logic signed [PW-1:0] dx, dy, ndx, ndy;
  logic [CW-1:0]        adx, ady, ma_s, ma_e, mi_s, mi_e, ma0, ma1, mi0;
  logic [CW-1:0]        dmaj, dmin;
  logic                 y_major, swap, minor_neg;

  always_comb begin
    dx      = signed'({1'b0, x_end_i}) - signed'({1'b0, x_start_i});
    dy      = signed'({1'b0, y_end_i}) - signed'({1'b0, y_start_i});
    ndx     = -dx;
    ndy     = -dy;
    adx     = dx[PW-1] ? ndx[CW-1:0] : dx[CW-1:0];
    ady     = dy[PW-1] ? ndy[CW-1:0] : dy[CW-1:0];
    y_major = ady > adx;
    ma_s    = y_major ? y_start_i : x_start_i;
    ma_e    = y_major ? y_end_i   : x_end_i;
    mi_s    = y_major ? x_start_i : y_start_i;
    mi_e    = y_major ? x_end_i   : y_end_i;
    swap    = ma_s > ma_e;
    ma0     = swap ? ma_e : ma_s;
    ma1     = swap ? ma_s : ma_e;
    mi0     = swap ? mi_e : mi_s;
    dmaj    = y_major ? ady : adx;
    dmin    = y_major ? adx : ady;
    minor_neg = (y_major ? dx[PW-1] : dy[PW-1]) ^ swap;
  end

  // Slope division
  logic          div_done;
  logic [AW-1:0] quotient;
  logic [QW-1:0] q_mag;
  logic signed [SW-1:0] slope_pos, slope_new;

  dla_div #(
    .DIVIDEND_W (AW),
    .DIVISOR_W  (CW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i ({dmin_q, {FRAC_BITS{1'b0}}}),
    .divisor_i  (dmaj_q),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  always_comb begin
    q_mag     = quotient[QW-1:0];
    slope_pos = signed'({1'b0, q_mag});
    slope_new = neg_q ? -slope_pos : slope_pos;
  end

  // Step values derived from the accumulator
  logic [CW-1:0]        f_int;
  logic [BLEND_W-1:0]   frac_e;
  logic [AW:0]          rnd_sum;
  logic [PW-1:0]        minor_rnd, minor_fl, minor_nx, pos_ext;
  logic                 last_flag;
  logic signed [AW:0]   acc_sum;
  logic [CW-1:0]        pos_inc;

  always_comb begin
    f_int     = acc_q[AW-1:FRAC_BITS];
    frac_e    = acc_q[FRAC_BITS-1 -: BLEND_W];
    rnd_sum   = {1'b0, acc_q} + ((AW+1)'(1) << (FRAC_BITS - 1));
    minor_rnd = rnd_sum[AW:FRAC_BITS];
    minor_fl  = {1'b0, f_int};
    minor_nx  = minor_fl + PW'(1);
    pos_ext   = {1'b0, pos_q};
    last_flag = (pos_ext + PW'(1)) == {1'b0, limit_q};
    acc_sum   = signed'({1'b0, acc_q}) + (AW+1)'(slope_q);
    pos_inc   = pos_q + CW'(1);
  end

  // Blend products, one per channel: (line - background) * e
  logic signed [CHAN_W:0] ch_diff [NUM_CHAN];
  logic signed [MW-1:0]   ch_prod [NUM_CHAN];
  logic signed [MW-1:0]   t0 [NUM_CHAN];
  logic signed [MW-1:0]   t1 [NUM_CHAN];
  logic [COLOR_W-1:0]     color0, color1;

  always_comb begin
    for (int c = 0; c < NUM_CHAN; c++) begin
      ch_diff[c] = signed'({1'b0, line_color_i[c*CHAN_W +: CHAN_W]})
                 - signed'({1'b0, bg_q[c*CHAN_W +: CHAN_W]});
      ch_prod[c] = MW'(ch_diff[c]) * MW'(signed'({1'b0, frac_e}));
      // floor pixel: line + floor((128 - p) / 256); next pixel: bg + floor((p + 128) / 256)
      t0[c] = MW'(BLEND_RND) - prod_q[c];
      t1[c] = prod_q[c] + MW'(BLEND_RND);
      color0[c*CHAN_W +: CHAN_W] = line_color_i[c*CHAN_W +: CHAN_W] + t0[c][15:8];
      color1[c*CHAN_W +: CHAN_W] = bg_q[c*CHAN_W +: CHAN_W] + t1[c][15:8];
    end
  end

  // Result selection
  always_comb begin
    px_d    = px_q;
    py_d    = py_q;
    color_d = color_q;
    last_d  = last_q;
    if (cmd_i.emit0) begin
      px_d    = y_major_q ? (mode_q ? minor_fl : minor_rnd) : pos_ext;
      py_d    = y_major_q ? pos_ext : (mode_q ? minor_fl : minor_rnd);
      color_d = mode_q ? color0 : line_color_i;
      last_d  = mode_q ? 1'b0 : last_flag;
    end else if (cmd_i.emit1) begin
      px_d    = y_major_q ? minor_nx : pos_ext;
      py_d    = y_major_q ? pos_ext : minor_nx;
      color_d = color1;
      last_d  = last_flag;
    end
  end

  always_comb begin
    if (cmd_i.emit0 || cmd_i.emit1) begin
      out_valid_d = 1'b1;
    end else begin
      out_valid_d = out_valid_q && out_stall_i;
    end
  end

  // Control state of the line
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (cmd_i.ld_line || cmd_i.kill) begin
        active_q <= 1'b0;
      end else if (cmd_i.slope_wr) begin
        active_q <= 1'b1;
      end else if (cmd_i.advance && last_flag) begin
        active_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_line) begin
      pos_q     <= ma0;
      limit_q   <= ma1;
      acc_q     <= {mi0, {FRAC_BITS{1'b0}}};
      bg_q      <= background_color_i;
      y_major_q <= y_major;
      neg_q     <= minor_neg;
      dmaj_q    <= dmaj;
      dmin_q    <= dmin;
      slope_q   <= '0;
    end else if (cmd_i.slope_wr) begin
      slope_q <= slope_new;
    end else if (cmd_i.advance) begin
      // clamp the minor position at zero
      acc_q <= acc_sum[AW] ? '0 : acc_sum[AW-1:0];
      pos_q <= pos_inc;
    end
    if (cmd_i.mul_en) begin
      mode_q <= antialias_on_i;
      for (int c = 0; c < NUM_CHAN; c++) begin
        prod_q[c] <= ch_prod[c];
      end
    end
    px_q    <= px_d;
    py_q    <= py_d;
    color_q <= color_d;
    last_q  <= last_d;
  end

  always_comb begin
    status_o.degenerate = (dmaj == '0);
    status_o.step_ok    = active_q && (pos_q < limit_q);
    status_o.aa_mode    = mode_q;
    status_o.div_done   = div_done;
    status_o.out_free   = !out_valid_q || !out_stall_i;
  end

  assign out_valid_o    = out_valid_q;
  assign pixel_x_o      = px_q;
  assign pixel_y_o      = py_q;
  assign pixel_color_o  = color_q;
  assign last_of_line_o = last_q;

`ifndef NO_ASSERTIONS
  // A pending pixel is never overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit0 || cmd_i.emit1) |-> (!out_valid_q || !out_stall_i))
    else $error("pixel emitted over a pending result");

  // The line only advances while a step remains
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.advance |-> (active_q && (pos_q < limit_q)))
    else $error("advance without a remaining step");

  // The slope is written only for a freshly loaded line
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.slope_wr |-> (div_done && !active_q))
    else $error("slope written outside a division");
`endif

endmodule

`default_nettype wire

>>> rtl/core/dla_ctrl.sv
`default_nettype none

module dla_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic                cmd_i,
  input  wire dla_pkg::dp_status_t status_i,
  output dla_pkg::dp_cmd_t         dp_cmd_o
);

  import dla_pkg::*;

  state_e state_q, state_d;
  logic   in_accept;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          if (cmd_i == CMD_LOAD) begin
            state_d = status_i.degenerate ? ST_IDLE : ST_DIV_START;
          end else if (status_i.step_ok) begin
            state_d = ST_MUL;
          end
        end
      end
      ST_DIV_START: state_d = ST_DIV;
      ST_DIV: begin
        if (status_i.div_done) state_d = ST_IDLE;
      end
      ST_MUL: state_d = ST_PIX0;
      ST_PIX0: begin
        if (status_i.out_free) state_d = status_i.aa_mode ? ST_PIX1 : ST_IDLE;
      end
      ST_PIX1: begin
        if (status_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath commands
  always_comb begin
    dp_cmd_o = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          if (cmd_i == CMD_LOAD) begin
            dp_cmd_o.ld_line = 1'b1;
          end else if (!status_i.step_ok) begin
            dp_cmd_o.kill = 1'b1;
          end
        end
      end
      ST_DIV_START: dp_cmd_o.div_start = 1'b1;
      ST_DIV: dp_cmd_o.slope_wr = status_i.div_done;
      ST_MUL: dp_cmd_o.mul_en = 1'b1;
      ST_PIX0: begin
        if (status_i.out_free) begin
          dp_cmd_o.emit0   = 1'b1;
          dp_cmd_o.advance = !status_i.aa_mode;
        end
      end
      ST_PIX1: begin
        if (status_i.out_free) begin
          dp_cmd_o.emit1   = 1'b1;
          dp_cmd_o.advance = 1'b1;
        end
      end
      default: dp_cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/dda_line_rasterizer_antialias.sv
`default_nettype none

// Antialiased DDA line rasterizer. A load request (cmd 0) latches two endpoints
// and a background colour, picks the major axis and divides once for the minor
// slope; each step request (cmd 1) then yields the pixel or pixels of one major
// coordinate, with last_of_line on the final one. A load runs through the
// restoring divider, which produces one quotient bit per cycle; a step passes
// the product register of the channel blend and then emits its pixel, or two
// pixels in antialias mode, through the output register, waiting while the
// output is stalled. A load of a degenerate line and a step with no line left
// are finished in the cycle in which they are accepted. The block accepts one
// request at a time; a finished pixel may wait in the output register while
// the next request is taken. Line colour sits at byte address 0 and the
// antialias enable at address 4 of the configuration port.
module dda_line_rasterizer_antialias #(
  parameter int COORD_BITS = dla_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = dla_pkg::FRAC_BITS_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [dla_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [dla_pkg::APB_DATA_W-1:0] pwdata,
  output logic [dla_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                pready,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic                           cmd_i,
  input  wire logic [COORD_BITS-1:0]          x_start_i,
  input  wire logic [COORD_BITS-1:0]          y_start_i,
  input  wire logic [COORD_BITS-1:0]          x_end_i,
  input  wire logic [COORD_BITS-1:0]          y_end_i,
  input  wire logic [dla_pkg::COLOR_W-1:0]    background_color_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic [COORD_BITS:0]                 pixel_x_o,
  output logic [COORD_BITS:0]                 pixel_y_o,
  output logic [dla_pkg::COLOR_W-1:0]         pixel_color_o,
  output logic                                last_of_line_o
);

  import dla_pkg::*;

  logic [COLOR_W-1:0] line_color_q;
  logic               antialias_q;
  logic               cfg_wr;
  logic               reg_sel;
  dp_cmd_t            dp_cmd;
  dp_status_t         dp_status;

  // Configuration registers
  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_color_q <= LINE_COLOR_RST;
      antialias_q  <= 1'b0;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_LINE_COLOR: line_color_q <= pwdata[COLOR_W-1:0];
        REG_ANTIALIAS:  antialias_q  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_LINE_COLOR: prdata = APB_DATA_W'(line_color_q);
      REG_ANTIALIAS:  prdata = APB_DATA_W'(antialias_q);
      default:        prdata = '0;
    endcase
  end

  dla_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cmd_i      (cmd_i),
    .status_i   (dp_status),
    .dp_cmd_o   (dp_cmd)
  );

  dla_datapath #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (dp_cmd),
    .status_o           (dp_status),
    .x_start_i          (x_start_i),
    .y_start_i          (y_start_i),
    .x_end_i            (x_end_i),
    .y_end_i            (y_end_i),
    .background_color_i (background_color_i),
    .line_color_i       (line_color_q),
    .antialias_on_i     (antialias_q),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .pixel_x_o          (pixel_x_o),
    .pixel_y_o          (pixel_y_o),
    .pixel_color_o      (pixel_color_o),
    .last_of_line_o     (last_of_line_o)
  );

endmodule

`default_nettype wire
